[hw/rtl/elrh_pkg.sv]
package elrh_pkg;

  // Item opcodes
  localparam logic [1:0] OP_ESTOP = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_FATAL = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Command origin
  localparam logic [1:0] SRC_OTHER   = 2'd0;
  localparam logic [1:0] SRC_INPUT   = 2'd1;
  localparam logic [1:0] SRC_SORTING = 2'd2;

  // Domain status
  localparam logic [1:0] SYNC_STOPPED  = 2'd1;
  localparam logic [1:0] SYNC_RELEASED = 2'd2;

  // Release handshake phases (code 3 never stored, reads as idle)
  localparam logic [1:0] PH_IDLE          = 2'd0;
  localparam logic [1:0] PH_WAIT_STOPPED  = 2'd1;
  localparam logic [1:0] PH_WAIT_RELEASED = 2'd2;
  localparam logic [1:0] PH_SPARE         = 2'd3;

  // Event kinds
  localparam logic [1:0] EV_LATCHED  = 2'd0;
  localparam logic [1:0] EV_REJECTED = 2'd1;
  localparam logic [1:0] EV_COMPLETE = 2'd2;

  // Reset result codes
  localparam logic [1:0] RC_OK          = 2'd0;
  localparam logic [1:0] RC_TIMEOUT     = 2'd1;
  localparam logic [1:0] RC_INPUT_NR    = 2'd2;
  localparam logic [1:0] RC_SORTING_NR  = 2'd3;

  // Motor actions
  localparam logic [1:0] MA_NONE    = 2'd0;
  localparam logic [1:0] MA_LATCH   = 2'd1;
  localparam logic [1:0] MA_RELEASE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_ATTEMPTS  = 2'd0;
  localparam logic [1:0] CFG_CAUSE_INPUT   = 2'd1;
  localparam logic [1:0] CFG_CAUSE_SORTING = 2'd2;

  localparam logic [15:0] MAX_ATTEMPTS_RST  = 16'd250;
  localparam logic [7:0]  CAUSE_INPUT_RST   = 8'd1;
  localparam logic [7:0]  CAUSE_SORTING_RST = 8'd2;

  // Result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic        event_valid;
    logic [1:0]  event_kind;
    logic [1:0]  event_targets;
    logic [7:0]  event_cause;
    logic [31:0] event_time;
    logic [1:0]  reset_code;
    logic [1:0]  motor_action;
    logic        release_request;
    logic [1:0]  latched_mask;
    logic        releasing;
    logic        last;
  } res_t;

  // Push request from the step logic to the result queue
  typedef struct packed {
    logic en;
    logic two;
  } push_t;

endpackage

[hw/rtl/elrh_in_if.sv]
interface elrh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  source_channel;
  logic [7:0]  fatal_cause;
  logic [31:0] now_tick;
  logic [1:0]  input_sync;
  logic [1:0]  sorting_sync;
  logic        input_release_accepted;
  logic        sorting_release_accepted;

  modport source (
    output valid, opcode, source_channel, fatal_cause, now_tick, input_sync,
           sorting_sync, input_release_accepted, sorting_release_accepted,
    input  ready
  );
  modport sink (
    input  valid, opcode, source_channel, fatal_cause, now_tick, input_sync,
           sorting_sync, input_release_accepted, sorting_release_accepted,
    output ready
  );
endinterface

[hw/rtl/elrh_out_if.sv]
interface elrh_out_if;
  logic        valid;
  logic        ready;
  logic        event_valid;
  logic [1:0]  event_kind;
  logic [1:0]  event_targets;
  logic [7:0]  event_cause;
  logic [31:0] event_time;
  logic [1:0]  reset_code;
  logic [1:0]  motor_action;
  logic        release_request;
  logic [1:0]  latched_mask;
  logic        releasing;
  logic        last;

  modport source (
    output valid, event_valid, event_kind, event_targets, event_cause, event_time,
           reset_code, motor_action, release_request, latched_mask, releasing, last,
    input  ready
  );
  modport sink (
    input  valid, event_valid, event_kind, event_targets, event_cause, event_time,
           reset_code, motor_action, release_request, latched_mask, releasing, last,
    output ready
  );
endinterface

[hw/rtl/elrh_cfg_if.sv]
interface elrh_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/elrh_core.sv]
module elrh_core
  import elrh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  elrh_in_if.sink    item,
  elrh_cfg_if.sink   cfg,
  input  logic       space,
  output push_t      push,
  output res_t       res_a,
  output res_t       res_b
);

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] poll;
    logic        made;
    logic        relreq;
    logic        clr;
    logic        ev_valid;
    logic [1:0]  kind;
    logic [1:0]  code;
    logic [1:0]  motor;
  } svc_t;

  // Configuration registers
  logic [15:0] max_attempts;
  logic [7:0]  cause_code_input;
  logic [7:0]  cause_code_sorting;

  // Latch state
  logic        estop_active, estop_active_next;
  logic [1:0]  phase [2];
  logic [1:0]  phase_next [2];
  logic [15:0] poll [2];
  logic [15:0] poll_next [2];
  logic [1:0]  latched, latched_next;
  logic [7:0]  stored_cause, stored_cause_next;

  logic        accept;
  logic        rst_dom;
  logic        rel;
  logic [7:0]  latch_cause;
  svc_t        svc0, svc1;
  res_t        r0, r1;

  // One service poll of a single domain's release handshake
  function automatic svc_t service_dom(
    input logic [1:0]  ph,
    input logic [15:0] pc,
    input logic [1:0]  sync,
    input logic        acc,
    input logic        dom,
    input logic [15:0] max_att
  );
    svc_t        s;
    logic        fail;
    logic [1:0]  fcode;
    logic [15:0] cnt;
    s       = '0;
    s.phase = ph;
    s.poll  = pc;
    fail    = 1'b0;
    fcode   = RC_TIMEOUT;
    cnt     = pc + 16'd1;
    unique case (ph)
      PH_WAIT_STOPPED: begin
        if (sync == SYNC_STOPPED) begin
          if (acc) begin
            s.phase  = PH_WAIT_RELEASED;
            s.poll   = '0;
            s.relreq = 1'b1;
            s.made   = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end else begin
          fail  = 1'b1;
          fcode = dom ? RC_SORTING_NR : RC_INPUT_NR;
        end
      end
      PH_WAIT_RELEASED: begin
        if (sync == SYNC_RELEASED) begin
          s.phase    = PH_IDLE;
          s.poll     = '0;
          s.clr      = 1'b1;
          s.ev_valid = 1'b1;
          s.kind     = EV_COMPLETE;
          s.motor    = MA_RELEASE;
          s.made     = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
        s.phase = PH_IDLE;
      end
    endcase
    // failed poll: count, reject the phase at the limit
    if (fail) begin
      if (cnt >= max_att) begin
        s.phase    = PH_IDLE;
        s.poll     = '0;
        s.ev_valid = 1'b1;
        s.kind     = EV_REJECTED;
        s.code     = fcode;
        s.made     = 1'b1;
      end else begin
        s.poll = cnt;
      end
    end
    return s;
  endfunction

  assign accept     = item.valid & item.ready;
  assign item.ready = space;
  assign cfg.ready  = 1'b1;

  assign svc0 = service_dom(phase[0], poll[0], item.input_sync,
                            item.input_release_accepted, 1'b0, max_attempts);
  assign svc1 = service_dom(phase[1], poll[1], item.sorting_sync,
                            item.sorting_release_accepted, 1'b1, max_attempts);

  // Per-domain result words (status fields filled in below)
  always_comb begin
    r0                 = '0;
    r0.event_valid     = svc0.ev_valid;
    r0.event_kind      = svc0.kind;
    r0.event_targets   = 2'b01;
    r0.event_cause     = svc0.ev_valid ? stored_cause : 8'd0;
    r0.event_time      = svc0.ev_valid ? item.now_tick : 32'd0;
    r0.reset_code      = svc0.code;
    r0.motor_action    = svc0.motor;
    r0.release_request = svc0.relreq;
    r1                 = '0;
    r1.event_valid     = svc1.ev_valid;
    r1.event_kind      = svc1.kind;
    r1.event_targets   = 2'b10;
    r1.event_cause     = svc1.ev_valid ? stored_cause : 8'd0;
    r1.event_time      = svc1.ev_valid ? item.now_tick : 32'd0;
    r1.reset_code      = svc1.code;
    r1.motor_action    = svc1.motor;
    r1.release_request = svc1.relreq;
  end

  assign latch_cause = (item.opcode == OP_FATAL) ? item.fatal_cause :
                       (item.source_channel == SRC_SORTING) ? cause_code_sorting :
                       cause_code_input;
  assign rst_dom = (item.source_channel == SRC_SORTING);

  // Step logic for one item
  always_comb begin
    estop_active_next = estop_active;
    phase_next[0]     = phase[0];
    phase_next[1]     = phase[1];
    poll_next[0]      = poll[0];
    poll_next[1]      = poll[1];
    latched_next      = latched;
    stored_cause_next = stored_cause;
    res_a             = '0;
    res_b             = '0;
    push.en           = accept;
    push.two          = 1'b0;
    unique case (item.opcode) inside
      OP_ESTOP, OP_FATAL: begin
        estop_active_next   = 1'b1;
        phase_next[0]       = PH_IDLE;
        phase_next[1]       = PH_IDLE;
        poll_next[0]        = '0;
        poll_next[1]        = '0;
        latched_next        = 2'b11;
        stored_cause_next   = latch_cause;
        res_a.event_valid   = 1'b1;
        res_a.event_kind    = EV_LATCHED;
        res_a.event_targets = 2'b11;
        res_a.event_cause   = latch_cause;
        res_a.event_time    = item.now_tick;
        res_a.motor_action  = MA_LATCH;
      end
      OP_RESET: begin
        if ((item.source_channel == SRC_INPUT || item.source_channel == SRC_SORTING) &&
            latched[rst_dom] &&
            (phase[rst_dom] == PH_IDLE || phase[rst_dom] == PH_SPARE)) begin
          phase_next[rst_dom] = PH_WAIT_STOPPED;
          poll_next[rst_dom]  = '0;
        end
      end
      OP_TICK: begin
        if (estop_active) begin
          phase_next[0] = svc0.phase;
          phase_next[1] = svc1.phase;
          poll_next[0]  = svc0.poll;
          poll_next[1]  = svc1.poll;
          latched_next  = latched & ~{svc1.clr, svc0.clr};
          if ((svc0.clr || svc1.clr) && latched_next == 2'b00) begin
            estop_active_next = 1'b0;
          end
          // input domain first; an empty tick leaves a status word
          if (svc0.made) begin
            res_a = r0;
            if (svc1.made) begin
              res_b    = r1;
              push.two = 1'b1;
            end
          end else if (svc1.made) begin
            res_a = r1;
          end
        end
      end
      default: begin
      end
    endcase
    rel = estop_active_next &&
          (phase_next[0] != PH_IDLE || phase_next[1] != PH_IDLE);
    res_a.latched_mask = latched_next;
    res_a.releasing    = rel;
    res_a.last         = ~push.two;
    res_b.latched_mask = latched_next;
    res_b.releasing    = rel;
    res_b.last         = 1'b1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      estop_active <= 1'b0;
      phase[0]     <= PH_IDLE;
      phase[1]     <= PH_IDLE;
      poll[0]      <= '0;
      poll[1]      <= '0;
      latched      <= '0;
      stored_cause <= '0;
    end else if (accept) begin
      estop_active <= estop_active_next;
      phase[0]     <= phase_next[0];
      phase[1]     <= phase_next[1];
      poll[0]      <= poll_next[0];
      poll[1]      <= poll_next[1];
      latched      <= latched_next;
      stored_cause <= stored_cause_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts       <= MAX_ATTEMPTS_RST;
      cause_code_input   <= CAUSE_INPUT_RST;
      cause_code_sorting <= CAUSE_SORTING_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_MAX_ATTEMPTS:  max_attempts       <= cfg.data;
        CFG_CAUSE_INPUT:   cause_code_input   <= cfg.data[7:0];
        CFG_CAUSE_SORTING: cause_code_sorting <= cfg.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // estop active only while some domain is still latched
  a_active_latched: assert property (@(posedge clk) disable iff (rst)
    estop_active |-> latched != 2'b00)
    else $error("estop active with no latched domain");

  // a running handshake belongs to a latched domain
  a_phase_latched: assert property (@(posedge clk) disable iff (rst)
    (phase[0] == PH_IDLE || latched[0]) && (phase[1] == PH_IDLE || latched[1]))
    else $error("handshake running on an unlatched domain");

  // an accepted estop or fatal trigger latches both domains
  a_latch_all: assert property (@(posedge clk) disable iff (rst)
    accept && (item.opcode == OP_ESTOP || item.opcode == OP_FATAL) |=>
      estop_active && latched == 2'b11 && phase[0] == PH_IDLE && phase[1] == PH_IDLE)
    else $error("estop did not latch both domains");

endmodule

[hw/rtl/elrh_fifo.sv]
module elrh_fifo
  import elrh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  push_t       push,
  input  res_t        res_a,
  input  res_t        res_b,
  output logic        space,
  elrh_out_if.source  result
);

  res_t                 mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [RES_PTR_W-1:0] wr_ptr_b;
  logic [RES_CNT_W-1:0] count;
  logic [RES_CNT_W-1:0] push_n;
  logic                 pop;
  res_t                 head;

  assign pop      = result.valid & result.ready;
  assign push_n   = push.en ? (push.two ? RES_CNT_W'(2) : RES_CNT_W'(1)) : '0;
  assign wr_ptr_b = wr_ptr + RES_PTR_W'(1);
  // room for the largest burst one item can leave
  assign space    = (count <= RES_CNT_W'(RES_DEPTH - 2));

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[RES_PTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      count <= count + push_n - RES_CNT_W'(pop);
    end
  end

  // Result storage
  always_ff @(posedge clk) begin
    if (push.en) begin
      mem[wr_ptr] <= res_a;
      if (push.two) begin
        mem[wr_ptr_b] <= res_b;
      end
    end
  end

  // Head word onto the port
  assign head                   = mem[rd_ptr];
  assign result.valid           = (count != '0);
  assign result.event_valid     = head.event_valid;
  assign result.event_kind      = head.event_kind;
  assign result.event_targets   = head.event_targets;
  assign result.event_cause     = head.event_cause;
  assign result.event_time      = head.event_time;
  assign result.reset_code      = head.reset_code;
  assign result.motor_action    = head.motor_action;
  assign result.release_request = head.release_request;
  assign result.latched_mask    = head.latched_mask;
  assign result.releasing       = head.releasing;
  assign result.last            = head.last;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.en |-> space)
    else $error("push without room");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push.en |=> result.valid)
    else $error("pushed word not presented");

endmodule

[hw/rtl/estop_latch_release_handshake.sv]
// Channel  | Dir | Handshake      | Word
// item     | in  | valid / ready  | opcode, source, fatal cause, time, domain status
// result   | out | valid / ready  | event report and latch status, last flag
// cfg      | in  | valid / ready  | register index, write data (ready always high)
//
// An item is worked out in the cycle it is accepted; its one or two result words
// are written into the result queue at that same edge, offered behind words queued
// before. A new item follows every cycle while the four-word queue has room for two.
// Synchronous active-high reset: latch cleared, registers to defaults.
// A stalled result side fills the queue and then drops item ready.
module estop_latch_release_handshake
  import elrh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  elrh_in_if.sink     item,
  elrh_out_if.source  result,
  elrh_cfg_if.sink    cfg
);

  push_t push;
  res_t  res_a;
  res_t  res_b;
  logic  space;

  elrh_core u_core (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .cfg   (cfg),
    .space (space),
    .push  (push),
    .res_a (res_a),
    .res_b (res_b)
  );

  elrh_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .res_a  (res_a),
    .res_b  (res_b),
    .space  (space),
    .result (result)
  );

endmodule
